[design/mml_pkg.sv]
// Package for the multi-class margin loss block: payload structs, register
// indexes, widths and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mml_pkg;
  localparam int unsigned MaxClassesDefault = 256;
  localparam int unsigned AccW = 48;
  localparam int unsigned LossW = 32;

  localparam logic [2:0] RegMargin = 3'd0;
  localparam logic [2:0] RegPower = 3'd1;
  localparam logic [2:0] RegReduction = 3'd2;
  localparam logic [2:0] RegClassCount = 3'd3;
  localparam logic [2:0] RegBatchCount = 3'd4;

  localparam logic OpWeight = 1'b0;
  localparam logic OpScore = 1'b1;
  localparam logic [1:0] RedMean = 2'd2;

  typedef struct packed {
    logic              opcode;
    logic [7:0]        weight_class;
    logic [15:0]       weight_value;
    logic signed [15:0] score;
    logic [15:0]       target_class;
    logic              row_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] loss;
    logic        target_invalid;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_target; // latch target score and weight (read issued earlier)
    logic walk_acc;    // accumulate the term for the returned read
    logic clear_acc;
    logic start_div;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

[design/mml_divider.sv]
// Restoring divider, one quotient bit per cycle, for the loss reductions.
// Depends on mml_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mml_divider import mml_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [AccW-1:0] dividend_i,
  input  wire logic [15:0]     divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [AccW-1:0]      quot_o
);
  localparam int unsigned CntW = $clog2(AccW + 1);
  logic [AccW-1:0] q_q, q_d;
  logic [16:0]     r_q, r_d;
  logic [15:0]     dv_q;
  logic [CntW-1:0] cnt_q;
  logic [16:0]     trial;

  always_comb begin
    trial = {r_q[15:0], q_q[AccW-1]};
    r_d = trial;
    q_d = {q_q[AccW-2:0], 1'b0};
    if (trial >= {1'b0, dv_q}) begin
      r_d = trial - {1'b0, dv_q};
      q_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_o <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_o <= 1'b1;
        cnt_q <= CntW'(AccW);
      end else if (busy_o) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_o <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      dv_q <= divisor_i;
    end else if (busy_o) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end
  assign quot_o = q_q;
endmodule
`default_nettype wire

[design/mml_datapath.sv]
// Datapath: score and weight memories, hinge term pipeline, accumulator and
// divider. Depends on mml_pkg and mml_divider.
`timescale 1ns / 1ps
`default_nettype none
module mml_datapath import mml_pkg::*; #(
  parameter int unsigned MaxClasses = MaxClassesDefault,
  localparam int unsigned IdxW = $clog2(MaxClasses)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             sc_we_i,
  input  wire logic [IdxW-1:0]  sc_waddr_i,
  input  wire logic [15:0]      sc_wdata_i,
  input  wire logic             wt_we_i,
  input  wire logic [IdxW-1:0]  wt_waddr_i,
  input  wire logic [15:0]      wt_wdata_i,
  input  wire logic [IdxW-1:0]  rd_addr_i,
  input  wire logic             rd_is_target_i,
  input  wire logic signed [15:0] margin_i,
  input  wire logic             power_i,
  input  wire logic [15:0]      divisor_i,
  input  wire logic             div_src_acc_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_sts_t               sts_o,
  output logic [AccW-1:0]       quot_o
);
  logic [15:0] score_mem [MaxClasses];
  logic [15:0] wt_mem [MaxClasses];
  logic [MaxClasses-1:0] wt_valid_q;
  logic [15:0] sc_rd_q, wt_rd_q;
  logic        wt_rd_valid_q, skip_q, skip_d;
  logic signed [15:0] xy_q;
  logic [15:0] w_q;
  logic signed [17:0] t_q;
  logic        t_ok_q;
  logic [33:0] p1_q;
  logic        p1_ok_q;
  logic [AccW-1:0] acc_q, acc_d, term;
  logic [AccW:0] sum;
  logic [AccW-1:0] quot_d;
  logic div_start;
  logic [AccW-1:0] div_in;

  always_ff @(posedge clk_i) begin
    if (sc_we_i) score_mem[sc_waddr_i] <= sc_wdata_i;
    sc_rd_q <= score_mem[rd_addr_i];
    if (wt_we_i) wt_mem[wt_waddr_i] <= wt_wdata_i;
    wt_rd_q <= wt_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_valid_q <= '0;
      wt_rd_valid_q <= 1'b0;
    end else begin
      if (wt_we_i) wt_valid_q[wt_waddr_i] <= 1'b1;
      wt_rd_valid_q <= wt_valid_q[rd_addr_i];
    end
  end

  assign skip_d = rd_is_target_i;

  // Stage 1: hinge; stage 2: w*t; stage 3: optional *t and accumulate.
  logic signed [17:0] t_now;
  logic [17:0] t2_q;
  assign t_now = 18'(margin_i) - 18'(xy_q) + 18'(signed'(sc_rd_q));
  always_ff @(posedge clk_i) begin
    skip_q <= skip_d;
    if (cmd_i.load_target) begin
      xy_q <= signed'(sc_rd_q);
      w_q <= wt_rd_valid_q ? wt_rd_q : 16'd256;
    end
    t_q <= t_now;
    t_ok_q <= cmd_i.walk_acc && !skip_q && (t_now > 18'sd0);
    p1_q <= 34'(w_q) * 34'(t_q[16:0]);
    t2_q <= t_q;
    p1_ok_q <= t_ok_q;
  end

  logic [50:0] sq_prod;
  assign sq_prod = 51'(p1_q) * 51'(t2_q[16:0]);
  always_comb begin
    term = power_i ? AccW'(sq_prod >> 8) : AccW'(p1_q);
    sum = {1'b0, acc_q} + {1'b0, term};
    acc_d = acc_q;
    if (p1_ok_q) acc_d = sum[AccW] ? '1 : sum[AccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else if (cmd_i.clear_acc) acc_q <= '0;
    else acc_q <= acc_d;
  end

  assign div_start = cmd_i.start_div;
  assign div_in = div_src_acc_i ? acc_q : quot_d;

  mml_divider u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_in), .divisor_i(divisor_i),
    .busy_o(sts_o.div_busy), .done_o(sts_o.div_done), .quot_o(quot_d)
  );
  assign quot_o = quot_d;
endmodule
`default_nettype wire

[design/mml_ctrl.sv]
// Controller: sequences load, walk, drain and the division steps.
// Depends on mml_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mml_ctrl import mml_pkg::*; #(
  parameter int unsigned MaxClasses = MaxClassesDefault,
  localparam int unsigned IdxW = $clog2(MaxClasses),
  localparam int unsigned CntW = $clog2(MaxClasses + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire in_item_t        in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output out_item_t            out_data_o,
  input  wire logic [CntW-1:0] cc_i,
  input  wire logic [15:0]     bc_i,
  input  wire logic            mean_i,
  output logic                 sc_we_o,
  output logic [IdxW-1:0]      sc_waddr_o,
  output logic                 wt_we_o,
  output logic [IdxW-1:0]      rd_addr_o,
  output logic                 rd_is_target_o,
  output logic [15:0]          divisor_o,
  output logic                 div_src_acc_o,
  output dp_cmd_t              cmd_o,
  input  wire dp_sts_t         sts_i,
  input  wire logic [AccW-1:0] quot_i
);
  typedef enum logic [2:0] {
    S_LOAD, S_TGT, S_WALK, S_DRAIN, S_DIV1, S_DIV2, S_OUT
  } state_e;
  state_e state_q;
  logic [CntW-1:0] pos_q, cnt_q;
  logic [15:0] tgt_q;
  logic [2:0] drain_q;
  logic accept;
  logic [CntW-1:0] tgt_n;

  // Only the last score of a row can produce a result, so only that one waits
  // for the output register to empty.
  assign in_stall_o = (state_q != S_LOAD) ||
                      (out_valid_o && in_data_i.opcode == OpScore && in_data_i.row_last);
  assign accept = in_valid_i && !in_stall_o;
  assign sc_we_o = accept && in_data_i.opcode == OpScore && pos_q < CntW'(MaxClasses);
  assign sc_waddr_o = pos_q[IdxW-1:0];
  assign wt_we_o = accept && in_data_i.opcode == OpWeight &&
                   32'(in_data_i.weight_class) < MaxClasses;
  assign tgt_n = CntW'(tgt_q);
  assign rd_addr_o = (state_q == S_WALK) ? cnt_q[IdxW-1:0] : tgt_q[IdxW-1:0];
  assign rd_is_target_o = (state_q == S_WALK) && (cnt_q == tgt_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      pos_q <= '0;
      cnt_q <= '0;
      tgt_q <= '0;
      drain_q <= '0;
      out_valid_o <= 1'b0;
      out_data_o <= '0;
      cmd_o <= '0;
      divisor_o <= 16'd1;
      div_src_acc_o <= 1'b1;
    end else begin
      cmd_o <= '0;
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (accept && in_data_i.opcode == OpScore) begin
            tgt_q <= in_data_i.target_class;
            if (in_data_i.row_last) begin
              pos_q <= '0;
              cmd_o.clear_acc <= 1'b1;
              if (32'(in_data_i.target_class) >= 32'(cc_i)) begin
                out_data_o <= '{loss: '0, target_invalid: 1'b1};
                out_valid_o <= 1'b1;
              end else begin
                state_q <= S_TGT;
              end
            end else if (pos_q < CntW'(MaxClasses)) begin
              pos_q <= pos_q + 1'b1;
            end
          end
        end
        S_TGT: begin
          // Read the target entry; load_target is registered and latches it when the read returns.
          cmd_o.load_target <= 1'b1;
          cnt_q <= '0;
          state_q <= S_WALK;
        end
        S_WALK: begin
          cmd_o.walk_acc <= 1'b1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == cc_i - 1'b1) begin
            state_q <= S_DRAIN;
            drain_q <= 3'd4;
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q - 1'b1;
          if (drain_q == 3'd0) begin
            divisor_o <= 16'(cc_i);
            div_src_acc_o <= 1'b1;
            cmd_o.start_div <= 1'b1;
            state_q <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (sts_i.div_done) begin
            if (mean_i) begin
              divisor_o <= bc_i;
              div_src_acc_o <= 1'b0;
              cmd_o.start_div <= 1'b1;
              state_q <= S_DIV2;
            end else state_q <= S_OUT;
          end
        end
        S_DIV2: begin
          if (sts_i.div_done) state_q <= S_OUT;
        end
        S_OUT: begin
          out_data_o <= '{loss: (|quot_i[AccW-1:LossW]) ? '1 : quot_i[LossW-1:0],
                          target_invalid: 1'b0};
          out_valid_o <= 1'b1;
          state_q <= S_LOAD;
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/multi_margin_loss_row_top.sv]
// Top level of the multi-class margin loss block: configuration registers,
// controller and datapath. Depends on mml_pkg, mml_ctrl and mml_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Score transfers load one class a cycle into the row memory while the
// controller waits for input; all transfers are stalled during the walk and
// the division. After the last score of a row the controller walks the
// buffered row, one class a cycle through a single-port read of the score
// memory and a three-stage multiply pipeline, then divides the sum by the class
// count (and in mean mode by the batch count) with a one-bit-a-cycle divider.
// An invalid target returns its flag at once.
// The result waits in an output register; weight and score transfers are still
// taken meanwhile, but the last score of a row is held off until the waiting
// result has been taken.
module multi_margin_loss_row_top import mml_pkg::*; #(
  parameter int unsigned MaxClasses = MaxClassesDefault,
  localparam int unsigned IdxW = $clog2(MaxClasses),
  localparam int unsigned CntW = $clog2(MaxClasses + 1)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  logic signed [15:0] margin_q;
  logic power_q;
  logic [1:0] red_q;
  logic [8:0] cc_q;
  logic [15:0] bc_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= 16'sd256;
      power_q <= 1'b0;
      red_q <= '0;
      cc_q <= 9'd256;
      bc_q <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMargin: margin_q <= cfg_data_i[15:0];
        RegPower: power_q <= cfg_data_i[0];
        RegReduction: red_q <= cfg_data_i[1:0];
        RegClassCount: cc_q <= cfg_data_i[8:0];
        RegBatchCount: bc_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero reads as one, class count is capped at the table depth.
  logic [CntW-1:0] cc_eff;
  always_comb begin
    if (cc_q == '0) cc_eff = CntW'(1);
    else if (32'(cc_q) > MaxClasses) cc_eff = CntW'(MaxClasses);
    else cc_eff = CntW'(cc_q);
  end
  logic [15:0] bc_eff;
  assign bc_eff = (bc_q == '0) ? 16'd1 : bc_q;

  logic sc_we, wt_we, rd_tgt, src_acc;
  logic [IdxW-1:0] sc_wa, rd_a;
  logic [15:0] divisor;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [AccW-1:0] quot;

  mml_ctrl #(.MaxClasses(MaxClasses)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cc_i(cc_eff), .bc_i(bc_eff), .mean_i(red_q == RedMean),
    .sc_we_o(sc_we), .sc_waddr_o(sc_wa), .wt_we_o(wt_we), .rd_addr_o(rd_a),
    .rd_is_target_o(rd_tgt), .divisor_o(divisor), .div_src_acc_o(src_acc),
    .cmd_o(cmd), .sts_i(sts), .quot_i(quot)
  );

  mml_datapath #(.MaxClasses(MaxClasses)) u_dp (
    .clk_i, .rst_ni,
    .sc_we_i(sc_we), .sc_waddr_i(sc_wa), .sc_wdata_i(in_data_i.score),
    .wt_we_i(wt_we), .wt_waddr_i(IdxW'(in_data_i.weight_class)),
    .wt_wdata_i(in_data_i.weight_value),
    .rd_addr_i(rd_a), .rd_is_target_i(rd_tgt),
    .margin_i(margin_q), .power_i(power_q), .divisor_i(divisor),
    .div_src_acc_i(src_acc), .cmd_i(cmd), .sts_o(sts), .quot_o(quot)
  );
endmodule
`default_nettype wire

[design/multi_margin_loss_row_checker.sv]
// Port-level checker for the margin loss block, bound to the top level.
// Depends on mml_pkg.
`timescale 1ns / 1ps
`default_nettype none
module multi_margin_loss_row_checker import mml_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire in_item_t  in_data_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_valid_i && in_data_i.opcode == OpScore && in_data_i.row_last
    |-> in_stall_o) else $error("row end taken while result pending");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.target_invalid |-> out_data_o.loss == '0)
    else $error("invalid target with nonzero loss");
endmodule
bind multi_margin_loss_row_top multi_margin_loss_row_checker u_chk (.*);
`default_nettype wire
